@@ src/kmld_pkg.sv @@
// ---------------------------------------------------------------------------
// kmld_pkg: shared types and constants of the key matrix debounce unit
// Key phase encoding, per-key state record and default sizes.
// ---------------------------------------------------------------------------
package kmld_pkg;

    localparam int ROW_W         = 3;
    localparam int COL_W         = 3;
    localparam int LOCK_W        = 16;
    localparam int ROW_COUNT_DEF = 8;
    localparam int COL_COUNT_DEF = 8;

    typedef logic [LOCK_W-1:0] t_lock;

    localparam t_lock LOCK_RESET = t_lock'(100);
    localparam t_lock LOCK_ZERO  = t_lock'(0);
    localparam t_lock LOCK_ONE   = t_lock'(1);

    typedef enum logic [1:0] {
        PH_WAIT_PRESS   = 2'd0,
        PH_PRESS_LOCK   = 2'd1,
        PH_WAIT_RELEASE = 2'd2,
        PH_RELEASE_LOCK = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase phase;
        t_lock  left;
    } t_key_state;

endpackage

@@ src/key_matrix_lockout_debounce_unit.sv @@
// ---------------------------------------------------------------------------
// key_matrix_lockout_debounce_unit: per-key debounce with lockout
// Takes one key sample per beat and emits press and release events.
// ---------------------------------------------------------------------------
// Every key of the matrix runs its own four-phase machine (wait press, press
// lockout, wait release, release lockout) with a lockout counter. A sample
// that finds its key waiting and the contact changed emits one event beat
// (row, column, direction) and arms the counter with the lockout scan count;
// the key then ignores its contact until the visit on which the counter held
// one. A lockout scan count of zero acts as one. Samples outside the matrix
// are dropped without effect. The block accepts one sample every cycle while
// its input is not stalled; an event passes from the work stage into the output
// register. The per-key store is a memory with a registered read port, read as
// the sample is accepted and written back as it leaves the work stage; a
// sample of the same key right behind it takes the fresh value over a bypass,
// so repeated visits to one key still run at full rate. The input side stalls
// only while an event waits on a stalled output register. Reset clears the
// per-key state at once through one valid flag per key: there is no
// clearing pass. Write the lockout register only while the block is idle.
// ---------------------------------------------------------------------------
module key_matrix_lockout_debounce_unit #(
    parameter int ROW_COUNT = kmld_pkg::ROW_COUNT_DEF,
    parameter int COL_COUNT = kmld_pkg::COL_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_wr_en,
    input  logic [kmld_pkg::LOCK_W-1:0] i_cfg_wr_data,
    // sample channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [kmld_pkg::ROW_W-1:0] i_key_row,
    input  logic [kmld_pkg::COL_W-1:0] i_key_col,
    input  logic                       i_key_pressed,
    // event channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [kmld_pkg::ROW_W-1:0] o_event_row,
    output logic [kmld_pkg::COL_W-1:0] o_event_col,
    output logic                       o_event_press
);

    localparam int KEYS  = ROW_COUNT * COL_COUNT;
    localparam int IDX_W = (KEYS > 1) ? $clog2(KEYS) : 1;

    // lockout length register
    kmld_pkg::t_lock r_lock_len;
    kmld_pkg::t_lock lock_load;

    // per-key store and its valid flags
    kmld_pkg::t_key_state r_mem [KEYS];
    logic [KEYS-1:0]      r_key_valid;

    // work stage: sample plus registered read of its key
    logic                       r_s2_v;
    logic                       r_s2_inr;
    logic [kmld_pkg::ROW_W-1:0] r_s2_row;
    logic [kmld_pkg::COL_W-1:0] r_s2_col;
    logic                       r_s2_pressed;
    logic [IDX_W-1:0]           r_s2_idx;
    kmld_pkg::t_key_state       r_rd_data;
    logic                       r_rd_valid;
    logic                       r_byp;
    kmld_pkg::t_key_state       r_byp_data;

    // output register
    logic                       r_out_v;
    logic [kmld_pkg::ROW_W-1:0] r_out_row;
    logic [kmld_pkg::COL_W-1:0] r_out_col;
    logic                       r_out_press;

    logic                 in_accept;
    logic                 in_range;
    logic [31:0]          idx_full;
    logic [IDX_W-1:0]     rd_addr;
    kmld_pkg::t_key_state cur;
    kmld_pkg::t_key_state upd;
    logic                 emit;
    logic                 emit_dir;
    logic                 out_free;
    logic                 s2_go;
    logic                 wr_en;

    // Map the sample onto a key slot; an outside key reads slot zero.
    assign in_range = (32'(i_key_row) < 32'(ROW_COUNT)) && (32'(i_key_col) < 32'(COL_COUNT));
    assign idx_full = 32'(i_key_row) * 32'(COL_COUNT) + 32'(i_key_col);
    assign rd_addr  = in_range ? idx_full[IDX_W-1:0] : '0;

    assign lock_load = (r_lock_len == kmld_pkg::LOCK_ZERO) ? kmld_pkg::LOCK_ONE
                                                           : r_lock_len;

    // Resolve the key state: bypass first, then a never-written key reads as reset.
    always_comb begin
        if (r_byp) begin
            cur = r_byp_data;
        end else if (r_rd_valid) begin
            cur = r_rd_data;
        end else begin
            cur = '{phase: kmld_pkg::PH_WAIT_PRESS, left: kmld_pkg::LOCK_ZERO};
        end
    end

    // Phase update for the sample in the work stage.
    always_comb begin
        upd.phase = cur.phase;
        emit      = 1'b0;
        emit_dir  = 1'b0;
        case (cur.phase)
            kmld_pkg::PH_WAIT_PRESS: begin
                if (r_s2_pressed) begin
                    emit      = 1'b1;
                    emit_dir  = 1'b1;
                    upd.phase = kmld_pkg::PH_PRESS_LOCK;
                end
            end
            kmld_pkg::PH_PRESS_LOCK: begin
                if (cur.left == kmld_pkg::LOCK_ONE) begin
                    upd.phase = kmld_pkg::PH_WAIT_RELEASE;
                end
            end
            kmld_pkg::PH_WAIT_RELEASE: begin
                if (!r_s2_pressed) begin
                    emit      = 1'b1;
                    upd.phase = kmld_pkg::PH_RELEASE_LOCK;
                end
            end
            default: begin
                if (cur.left == kmld_pkg::LOCK_ONE) begin
                    upd.phase = kmld_pkg::PH_WAIT_PRESS;
                end
            end
        endcase
        emit = emit && r_s2_v && r_s2_inr;
        if (emit) begin
            upd.left = lock_load;
        end else if (cur.left != kmld_pkg::LOCK_ZERO) begin
            upd.left = cur.left - kmld_pkg::LOCK_ONE;
        end else begin
            upd.left = cur.left;
        end
    end

    // Retire the work stage unless its event would land on a full, stalled slot.
    assign out_free   = !r_out_v || !i_out_stall;
    assign s2_go      = r_s2_v && (!emit || out_free);
    assign wr_en      = s2_go && r_s2_inr;
    assign o_in_stall = r_s2_v && !s2_go;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Lockout register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_len <= kmld_pkg::LOCK_RESET;
        end else if (i_cfg_wr_en) begin
            r_lock_len <= i_cfg_wr_data;
        end
    end

    // Per-key memory: write back the update, read for the incoming sample.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_s2_idx] <= upd;
        end
        if (in_accept) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Valid flags: clear at reset, set on first write of a key.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_valid <= '0;
        end else if (wr_en) begin
            r_key_valid[r_s2_idx] <= 1'b1;
        end
    end

    // Work stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (in_accept) begin
            r_s2_v <= 1'b1;
        end else if (s2_go) begin
            r_s2_v <= 1'b0;
        end
    end

    // Work stage payload; catch a write to the same key on the accepting edge.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s2_inr     <= in_range;
            r_s2_row     <= i_key_row;
            r_s2_col     <= i_key_col;
            r_s2_pressed <= i_key_pressed;
            r_s2_idx     <= rd_addr;
            r_rd_valid   <= r_key_valid[rd_addr];
            r_byp        <= wr_en && (r_s2_idx == rd_addr);
            r_byp_data   <= upd;
        end
    end

    // Output register: load on an event, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s2_go && emit) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go && emit) begin
            r_out_row   <= r_s2_row;
            r_out_col   <= r_s2_col;
            r_out_press <= emit_dir;
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_event_row   = r_out_row;
    assign o_event_col   = r_out_col;
    assign o_event_press = r_out_press;

    // An event never overwrites a beat still waiting on the output.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_go && emit) |-> (!r_out_v || !i_out_stall))
        else $error("event loaded over a pending output beat");

    // A new output beat comes only from a retiring event.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> $past(s2_go && emit))
        else $error("output valid rose without an event");

    // A sample outside the matrix never raises an event.
    a_outside_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && !r_s2_inr) |-> !emit)
        else $error("event from a key outside the matrix");

    // Input stalls only behind an event waiting on a stalled output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (emit && r_out_v && i_out_stall))
        else $error("input stalled without a blocked event");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for key_matrix_lockout_debounce_unit
// Drives key samples and lockout settings into the block and predicts each
// press and release event from its own copy of the per-key state. Every
// event beat is compared field by field, in order, with the next expected
// event.
// ---------------------------------------------------------------------------

typedef struct packed {
    logic [kmld_pkg::ROW_W-1:0] row;
    logic [kmld_pkg::COL_W-1:0] col;
    logic                       press;
} t_key_event;

// Per-key debounce predictor with the queue of events still owed by the block.
class debounce_tracker;
    kmld_pkg::t_phase phase_of [kmld_pkg::ROW_COUNT_DEF*kmld_pkg::COL_COUNT_DEF];
    kmld_pkg::t_lock  left_of  [kmld_pkg::ROW_COUNT_DEF*kmld_pkg::COL_COUNT_DEF];
    kmld_pkg::t_lock  lock_len;
    t_key_event       pending_events [$];
    int               errors;
    int               samples;
    int               presses;
    int               releases;

    function new();
        foreach (phase_of[i]) begin
            phase_of[i] = kmld_pkg::PH_WAIT_PRESS;
            left_of[i]  = kmld_pkg::LOCK_ZERO;
        end
        lock_len = kmld_pkg::LOCK_RESET;
        errors   = 0;
        samples  = 0;
        presses  = 0;
        releases = 0;
    endfunction

    function void set_lockout(kmld_pkg::t_lock scans);
        lock_len = scans;
    endfunction

    function void note_sample(logic [kmld_pkg::ROW_W-1:0] row,
                              logic [kmld_pkg::COL_W-1:0] col, logic pressed);
        int               idx;
        kmld_pkg::t_phase ph;
        kmld_pkg::t_lock  left;
        kmld_pkg::t_lock  load;
        bit               fire;
        t_key_event       ev;
        samples++;
        if (int'(row) >= kmld_pkg::ROW_COUNT_DEF || int'(col) >= kmld_pkg::COL_COUNT_DEF)
            return;
        idx  = int'(row) * kmld_pkg::COL_COUNT_DEF + int'(col);
        ph   = phase_of[idx];
        left = left_of[idx];
        load = (lock_len == kmld_pkg::LOCK_ZERO) ? kmld_pkg::LOCK_ONE : lock_len;
        fire = 1'b0;
        case (ph)
            kmld_pkg::PH_WAIT_PRESS: begin
                if (pressed) begin
                    fire = 1'b1;
                    ph   = kmld_pkg::PH_PRESS_LOCK;
                end
            end
            kmld_pkg::PH_PRESS_LOCK: begin
                if (left == kmld_pkg::LOCK_ONE)
                    ph = kmld_pkg::PH_WAIT_RELEASE;
            end
            kmld_pkg::PH_WAIT_RELEASE: begin
                if (!pressed) begin
                    fire = 1'b1;
                    ph   = kmld_pkg::PH_RELEASE_LOCK;
                end
            end
            default: begin
                if (left == kmld_pkg::LOCK_ONE)
                    ph = kmld_pkg::PH_WAIT_PRESS;
            end
        endcase
        phase_of[idx] = ph;
        if (fire)
            left_of[idx] = load;
        else if (left != kmld_pkg::LOCK_ZERO)
            left_of[idx] = left - kmld_pkg::LOCK_ONE;
        if (fire) begin
            ev.row   = row;
            ev.col   = col;
            ev.press = (ph == kmld_pkg::PH_PRESS_LOCK);
            pending_events.push_back(ev);
        end
    endfunction

    function void check_event(t_key_event got);
        t_key_event want;
        if (pending_events.size() == 0) begin
            $display("%0t: unexpected event row %0d col %0d press %0b",
                     $time, got.row, got.col, got.press);
            errors++;
            return;
        end
        want = pending_events.pop_front();
        if (got.press) presses++;
        else           releases++;
        if (got.row !== want.row) begin
            $display("%0t: event row expected %0d, got %0d", $time, want.row, got.row);
            errors++;
        end
        if (got.col !== want.col) begin
            $display("%0t: event col expected %0d, got %0d", $time, want.col, got.col);
            errors++;
        end
        if (got.press !== want.press) begin
            $display("%0t: event press expected %0b, got %0b", $time, want.press, got.press);
            errors++;
        end
    endfunction
endclass

module tb;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int IDLE_PCT     = 18;
    localparam int DRAIN_CYCLES = 8;       // time for a last sample to clear the work stage
    localparam int CYCLE_LIMIT  = 200000;  // far beyond the slowest legal run
    localparam int PHASE_ITEMS  = 64;
    localparam int KEY_COUNT    = kmld_pkg::ROW_COUNT_DEF * kmld_pkg::COL_COUNT_DEF;

    // Drive every input to a known level from time zero.
    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_cfg_wr_en   = 1'b0;
    logic [kmld_pkg::LOCK_W-1:0] i_cfg_wr_data = '0;
    logic                        i_in_valid    = 1'b0;
    logic [kmld_pkg::ROW_W-1:0]  i_key_row     = '0;
    logic [kmld_pkg::COL_W-1:0]  i_key_col     = '0;
    logic                        i_key_pressed = 1'b0;
    logic                        i_out_stall   = 1'b0;
    logic                        o_in_stall;
    logic                        o_out_valid;
    logic [kmld_pkg::ROW_W-1:0]  o_event_row;
    logic [kmld_pkg::COL_W-1:0]  o_event_col;
    logic                        o_event_press;

    debounce_tracker board;
    bit              no_idle = 1'b1;       // set to suppress gaps on both sides
    logic            held_level [KEY_COUNT];
    int              cycle_count = 0;
    int              settings_seen = 1;    // reset value counts as the first

    key_matrix_lockout_debounce_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_key_row     (i_key_row),
        .i_key_col     (i_key_col),
        .i_key_pressed (i_key_pressed),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_event_row   (o_event_row),
        .o_event_col   (o_event_col),
        .o_event_press (o_event_press)
    );

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    // Stall the event channel at random, except in the quiet stretches.
    always @(posedge i_clk) begin
        i_out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Note every accepted sample beat; the predictor works out its event.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            board.note_sample(i_key_row, i_key_col, i_key_pressed);
    end

    // Check every accepted event beat against the oldest expected event.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_event('{row: o_event_row, col: o_event_col, press: o_event_press});
    end

    // Watchdog: drop the run if it has not finished within the cycle limit.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: errors");
        $finish;
    end

    // Offer one sample beat after random idle gaps, and hold it while the input stalls.
    task automatic send_sample(input logic [kmld_pkg::ROW_W-1:0] row,
                               input logic [kmld_pkg::COL_W-1:0] col,
                               input logic pressed);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_key_row     <= row;
        i_key_col     <= col;
        i_key_pressed <= pressed;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Write the lockout length once the block has gone quiet.
    task automatic write_lockout(input kmld_pkg::t_lock scans);
        i_in_valid <= 1'b0;
        while (board.pending_events.size() != 0) @(posedge i_clk);
        // A last sample that fires nothing may still be in flight.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= scans;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        board.set_lockout(scans);
        settings_seen++;
    endtask

    // One lockout setting: mostly a few keys pressed and released with
    // bounce on their level, the rest random keys and levels.
    task automatic run_phase(input kmld_pkg::t_lock scans);
        int pool [3];
        int k;
        int kr;
        int kc;
        logic level;
        write_lockout(scans);
        foreach (pool[i]) pool[i] = $urandom_range(0, KEY_COUNT - 1);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Hold a stretch of the phase free of gaps and stalls.
            no_idle = (n >= 16 && n < 40);
            if ($urandom_range(0, 99) < 80)
                k = pool[$urandom_range(0, 2)];
            else
                k = $urandom_range(0, KEY_COUNT - 1);
            if ($urandom_range(0, 99) < 20)
                held_level[k] = ~held_level[k];
            level = ($urandom_range(0, 99) < 90) ? held_level[k] : 1'($urandom_range(0, 1));
            kr = k / kmld_pkg::COL_COUNT_DEF;
            kc = k % kmld_pkg::COL_COUNT_DEF;
            send_sample(kr[kmld_pkg::ROW_W-1:0], kc[kmld_pkg::COL_W-1:0], level);
        end
    endtask

    initial begin
        board = new();
        foreach (held_level[i]) held_level[i] = 1'b0;

        // Hold reset, then release it once.
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, back to back so repeat visits hit the same-key bypass.
        // Reset lockout: corner keys press, contact ignored during lockout.
        no_idle = 1'b1;
        send_sample(3'd0, 3'd0, 1'b1);
        send_sample(3'd0, 3'd0, 1'b0);
        send_sample(3'd0, 3'd0, 1'b1);
        send_sample(3'd7, 3'd7, 1'b1);
        send_sample(3'd7, 3'd0, 1'b1);
        send_sample(3'd0, 3'd7, 1'b1);
        send_sample(3'd7, 3'd7, 1'b0);
        send_sample(3'd3, 3'd4, 1'b0);

        // Zero lockout length acts as one: the full cycle on a single key.
        write_lockout(kmld_pkg::LOCK_ZERO);
        send_sample(3'd2, 3'd5, 1'b1);
        send_sample(3'd2, 3'd5, 1'b0);
        send_sample(3'd2, 3'd5, 1'b0);
        send_sample(3'd2, 3'd5, 1'b1);
        send_sample(3'd2, 3'd5, 1'b1);
        send_sample(3'd2, 3'd5, 1'b1);
        send_sample(3'd2, 3'd5, 1'b1);
        send_sample(3'd2, 3'd5, 1'b0);

        // Lockout of two visits, interleaved with another key.
        write_lockout(kmld_pkg::t_lock'(2));
        send_sample(3'd5, 3'd2, 1'b1);
        send_sample(3'd6, 3'd1, 1'b1);
        send_sample(3'd5, 3'd2, 1'b0);
        send_sample(3'd5, 3'd2, 1'b0);
        send_sample(3'd5, 3'd2, 1'b0);
        send_sample(3'd6, 3'd1, 1'b0);

        // Random part over a spread of settings, extremes among them.
        run_phase(kmld_pkg::t_lock'(3));
        run_phase(kmld_pkg::LOCK_ONE);
        run_phase(kmld_pkg::t_lock'(5));
        run_phase(kmld_pkg::t_lock'(16'hFFFF));
        run_phase(kmld_pkg::LOCK_RESET);
        run_phase(kmld_pkg::t_lock'(4));

        // Drain: wait for every owed event, then let the pipeline settle.
        i_in_valid <= 1'b0;
        no_idle = 1'b1;
        while (board.pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d key samples over %0d lockout settings, %0d press and %0d release",
                 board.samples, settings_seen, board.presses, board.releases);
        $display("tb: events compared, with random gaps and stalls on both channels");
        if (board.errors == 0 && board.pending_events.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/kmld_pkg.sv
src/key_matrix_lockout_debounce_unit.sv
tb/tb.sv
